/* rtl/ir_pulse_distance_command_decoder_macros.svh */
// Assertion macros used by the checking file of the infrared decoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef IR_PULSE_DISTANCE_COMMAND_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define IRPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpd check failed");

// Next-cycle implication, switched off while reset is high.
`define IRPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irpd check failed");

// Next-cycle implication that also holds across reset.
`define IRPD_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("irpd check failed");

`endif

/* rtl/irpd_pkg.sv */
`default_nettype none

package irpd_pkg;

  // Field and register widths.
  localparam int IDX_W      = 6;
  localparam int CMD_W      = 8;
  localparam int TIMEOUT_W  = 20;
  localparam int LIMIT_W    = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 20'd20000;
  localparam logic [LIMIT_W-1:0]   ZERO_LIMIT_RESET = 16'd1300;
  localparam logic [LIMIT_W-1:0]   ONE_LIMIT_RESET  = 16'd2300;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_ZERO_LIMIT = 2'd2,
    CFG_ONE_LIMIT  = 2'd3
  } cfg_idx_t;

  // Current register settings as seen by the frame logic.
  typedef struct packed {
    logic                 enable;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [LIMIT_W-1:0]   zero_limit;
    logic [LIMIT_W-1:0]   one_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/ir_pulse_distance_command_decoder.sv */
// Pulse-distance infrared command decoder. Each input word is one sample of the
// receiver line, taken once per microsecond tick; the block takes one word every
// clock cycle unless a result waits untaken, and a word sits in the input register
// before it reaches the frame logic. The frame state (edge detector, tick counter,
// interval index, bit classes) is computed for a word combinationally, which sets
// that one-word-per-cycle rate. While enabled, a falling edge starts a frame, each
// later one closes an interval, and intervals FIRST_DATA_INTERVAL onwards give the
// command bits, least significant first. When no edge comes for timeout_ticks
// ticks, one result word with the command byte and interval count is offered from
// the result register; a waiting result stalls the input only if it is not taken.
// Registers: 0 enable, 1 timeout_ticks, 2 zero_limit, 3 one_limit; write them
// only while the block is idle.
`default_nettype none

module ir_pulse_distance_command_decoder #(
  parameter int MAX_INTERVALS       = 33,
  parameter int FIRST_DATA_INTERVAL = 17,
  parameter int DATA_BITS           = 8,
  parameter int TICK_WIDTH          = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             line_level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [irpd_pkg::CMD_W-1:0]            command,
  output logic [irpd_pkg::IDX_W-1:0]            intervals_seen
);

  irpd_pkg::cfg_t                  cfg;
  logic                            in_full;
  logic                            in_level;
  logic                            consume;
  logic                            emit;
  logic [irpd_pkg::CMD_W-1:0]      core_command;
  logic [irpd_pkg::IDX_W-1:0]      core_intervals;

  irpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held sample moves on whenever the result register has room.
  assign consume  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_level <= line_level;
    end
  end

  irpd_frame_core #(
    .MAX_INTERVALS       (MAX_INTERVALS),
    .FIRST_DATA_INTERVAL (FIRST_DATA_INTERVAL),
    .DATA_BITS           (DATA_BITS),
    .TICK_WIDTH          (TICK_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (consume),
    .level          (in_level),
    .emit           (emit),
    .command        (core_command),
    .intervals_seen (core_intervals)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      command        <= core_command;
      intervals_seen <= core_intervals;
    end
  end

endmodule

`default_nettype wire

/* rtl/irpd_cfg_regs.sv */
`default_nettype none

module irpd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output irpd_pkg::cfg_t                        cfg
);

  // Register file: one write per cycle, each register takes its low bits of the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.timeout_ticks <= irpd_pkg::TIMEOUT_RESET;
      cfg.zero_limit    <= irpd_pkg::ZERO_LIMIT_RESET;
      cfg.one_limit     <= irpd_pkg::ONE_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        irpd_pkg::CFG_ENABLE:     cfg.enable        <= cfg_data[0];
        irpd_pkg::CFG_TIMEOUT:    cfg.timeout_ticks <= cfg_data[irpd_pkg::TIMEOUT_W-1:0];
        irpd_pkg::CFG_ZERO_LIMIT: cfg.zero_limit    <= cfg_data[irpd_pkg::LIMIT_W-1:0];
        irpd_pkg::CFG_ONE_LIMIT:  cfg.one_limit     <= cfg_data[irpd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/irpd_frame_core.sv */
`default_nettype none

module irpd_frame_core #(
  parameter int MAX_INTERVALS       = 33,
  parameter int FIRST_DATA_INTERVAL = 17,
  parameter int DATA_BITS           = 8,
  parameter int TICK_WIDTH          = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire irpd_pkg::cfg_t                cfg,
  input  wire logic                          step,
  input  wire logic                          level,
  output logic                               emit,
  output logic [irpd_pkg::CMD_W-1:0]         command,
  output logic [irpd_pkg::IDX_W-1:0]         intervals_seen
);

  localparam int CMP_W = (TICK_WIDTH > irpd_pkg::TIMEOUT_W) ? TICK_WIDTH : irpd_pkg::TIMEOUT_W;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  logic                          last_level, last_level_next;
  logic                          frame_started, frame_started_next;
  logic [irpd_pkg::IDX_W-1:0]    interval_index, interval_index_next;
  logic [TICK_WIDTH-1:0]         tick_count, tick_count_next;
  logic [DATA_BITS-1:0]          bit_class, bit_class_next;

  logic [TICK_WIDTH-1:0]         tick_inc;
  logic [CMP_W-1:0]              len_ext;
  logic                          fall;
  logic                          take_edge;
  logic                          is_one;
  logic                          timed_out;

  // Saturating tick advance and the comparisons on the advanced count.
  always_comb begin
    tick_inc  = (tick_count == TICK_MAX) ? tick_count : tick_count + TICK_WIDTH'(1);
    len_ext   = CMP_W'(tick_inc);
    fall      = last_level & ~level;
    take_edge = fall & cfg.enable;
    is_one    = (len_ext >= CMP_W'(cfg.zero_limit)) && (len_ext < CMP_W'(cfg.one_limit));
    timed_out = frame_started && (len_ext >= CMP_W'(cfg.timeout_ticks));
  end

  // Frame state update for one line sample.
  always_comb begin
    last_level_next     = last_level;
    frame_started_next  = frame_started;
    interval_index_next = interval_index;
    tick_count_next     = tick_count;
    bit_class_next      = bit_class;
    emit                = 1'b0;
    if (step) begin
      last_level_next = level;
      if (take_edge) begin
        tick_count_next = '0;
        if (!frame_started) begin
          frame_started_next = 1'b1;
        end else if (interval_index < irpd_pkg::IDX_W'(MAX_INTERVALS)) begin
          // Classify the interval when it falls on a data position.
          for (int i = 0; i < DATA_BITS; i++) begin
            if (interval_index == irpd_pkg::IDX_W'(FIRST_DATA_INTERVAL + i)) begin
              bit_class_next[i] = is_one;
            end
          end
          interval_index_next = interval_index + irpd_pkg::IDX_W'(1);
        end
      end else if (timed_out) begin
        emit                = 1'b1;
        frame_started_next  = 1'b0;
        interval_index_next = '0;
        tick_count_next     = '0;
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  assign command        = irpd_pkg::CMD_W'(bit_class);
  assign intervals_seen = interval_index;

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b1;
      frame_started  <= 1'b0;
      interval_index <= '0;
      tick_count     <= '0;
      bit_class      <= '0;
    end else begin
      last_level     <= last_level_next;
      frame_started  <= frame_started_next;
      interval_index <= interval_index_next;
      tick_count     <= tick_count_next;
      bit_class      <= bit_class_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/irpd_checker.sv */
`default_nettype none

`include "ir_pulse_distance_command_decoder_macros.svh"

module irpd_checker #(
  parameter int MAX_INTERVALS = 33,
  parameter int DATA_BITS     = 8
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [irpd_pkg::CMD_W-1:0]   command,
  input wire logic [irpd_pkg::IDX_W-1:0]   intervals_seen
);

  // A stalled result word stays offered and unchanged.
  `IRPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(command) && $stable(intervals_seen))

  // Reset leaves no result word on offer.
  `IRPD_ASSERT_ALWAYS_NEXT(a_reset_clears, rst, !out_valid)

  // The input side only stalls behind a result word that is not being taken.
  `IRPD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)

  // The interval count never passes its saturation point.
  `IRPD_ASSERT_NOW(a_count_range, out_valid, intervals_seen <= irpd_pkg::IDX_W'(MAX_INTERVALS))

  // Command bits beyond the data positions are always zero.
  `IRPD_ASSERT_NOW(a_cmd_width, out_valid, (command >> DATA_BITS) == '0)

endmodule

bind ir_pulse_distance_command_decoder irpd_checker #(
  .MAX_INTERVALS (MAX_INTERVALS),
  .DATA_BITS     (DATA_BITS)
) u_irpd_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
module testbench;

  localparam int MAX_INTERVALS       = 33;
  localparam int FIRST_DATA_INTERVAL = 17;
  localparam int DATA_BITS           = 8;
  localparam int TICK_WIDTH          = 20;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  localparam int CMD_W      = irpd_pkg::CMD_W;
  localparam int IDX_W      = irpd_pkg::IDX_W;
  localparam int CFG_DATA_W = irpd_pkg::CFG_DATA_W;
  localparam int TIMEOUT_W  = irpd_pkg::TIMEOUT_W;
  localparam int LIMIT_W    = irpd_pkg::LIMIT_W;

  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int LIMIT_CYCLES    = 4000000;
  localparam int TARGET_SAMPLES  = 700;
  localparam int HOLD_OFF_PHASE  = 1;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_TOGGLE
  } ready_mode_t;

  // One decoded frame as it leaves the block.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] intervals;
  } frame_result_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_write  = 1'b0;
  irpd_pkg::cfg_idx_t    cfg_index  = irpd_pkg::CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  line_level = 1'b1;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [CMD_W-1:0]      command;
  logic [IDX_W-1:0]      intervals_seen;

  // Decoder copy: register settings and frame state.
  logic                  dec_enable;
  logic [TIMEOUT_W-1:0]  dec_timeout;
  logic [LIMIT_W-1:0]    dec_zero_limit;
  logic [LIMIT_W-1:0]    dec_one_limit;
  logic                  dec_last_level;
  logic                  dec_in_frame;
  logic [IDX_W-1:0]      dec_index;
  logic [TICK_WIDTH-1:0] dec_ticks;
  logic [DATA_BITS-1:0]  dec_bits;

  logic          pending_samples[$];
  frame_result_t expected_frames[$];

  int samples_accepted = 0;
  int result_errors    = 0;
  int burst_left       = 16;
  int gap_left         = 0;
  int hold_requests    = 0;
  int hold_seen        = 0;
  int hold_left        = 0;
  int mode_left        = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  ir_pulse_distance_command_decoder #(
    .MAX_INTERVALS       (MAX_INTERVALS),
    .FIRST_DATA_INTERVAL (FIRST_DATA_INTERVAL),
    .DATA_BITS           (DATA_BITS),
    .TICK_WIDTH          (TICK_WIDTH)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .line_level     (line_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .intervals_seen (intervals_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the decoder copy by one line sample and queue any frame it ends.
  function automatic void decode_sample(input logic level);
    logic          fall;
    int            pos;
    frame_result_t res;
    fall = dec_last_level && !level;
    dec_last_level = level;
    if (dec_ticks != TICK_MAX) dec_ticks = dec_ticks + 1'b1;
    if (fall && dec_enable) begin
      if (!dec_in_frame) begin
        dec_in_frame = 1'b1;
      end else if (dec_index < MAX_INTERVALS) begin
        if (dec_index >= FIRST_DATA_INTERVAL &&
            dec_index < FIRST_DATA_INTERVAL + DATA_BITS) begin
          pos = dec_index - FIRST_DATA_INTERVAL;
          dec_bits[pos] = (dec_ticks >= dec_zero_limit) && (dec_ticks < dec_one_limit);
        end
        dec_index = dec_index + 1'b1;
      end
      dec_ticks = '0;
    end else if (dec_in_frame && dec_ticks >= dec_timeout) begin
      res.command   = CMD_W'(dec_bits);
      res.intervals = dec_index;
      expected_frames.push_back(res);
      dec_in_frame = 1'b0;
      dec_index    = '0;
      dec_ticks    = '0;
    end
  endfunction

  // Sender: offers queued samples in bursts with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_sample(line_level);
        samples_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid   <= 1'b1;
          line_level <= pending_samples.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a changing pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= !out_ready;
        endcase
      end
    end
  end

  // Monitor: each result word is checked against the oldest expected frame.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        result_errors++;
        $display("%0t: unexpected result word, expected none, got command %0h intervals %0d",
                 $time, command, intervals_seen);
      end else begin
        want = expected_frames.pop_front();
        if (command !== want.command) begin
          result_errors++;
          $display("%0t: command mismatch, expected %0h, got %0h",
                   $time, want.command, command);
        end
        if (intervals_seen !== want.intervals) begin
          result_errors++;
          $display("%0t: interval count mismatch, expected %0d, got %0d",
                   $time, want.intervals, intervals_seen);
        end
      end
    end
  end

  task automatic write_reg(input irpd_pkg::cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      irpd_pkg::CFG_ENABLE:     dec_enable     = value[0];
      irpd_pkg::CFG_TIMEOUT:    dec_timeout    = value[TIMEOUT_W-1:0];
      irpd_pkg::CFG_ZERO_LIMIT: dec_zero_limit = value[LIMIT_W-1:0];
      default:                  dec_one_limit  = value[LIMIT_W-1:0];
    endcase
  endtask

  // Writes all four registers, then releases the write enable.
  task automatic apply_settings(input logic en, input int tmo, input int zl, input int ol);
    write_reg(irpd_pkg::CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(irpd_pkg::CFG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(irpd_pkg::CFG_ZERO_LIMIT, CFG_DATA_W'(zl));
    write_reg(irpd_pkg::CFG_ONE_LIMIT, CFG_DATA_W'(ol));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every queued sample is taken and every frame has come out.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_level(input logic level, input int count);
    for (int i = 0; i < count; i++) pending_samples.push_back(level);
  endtask

  // A falling edge, then a low run and a high run lasting span ticks in all.
  task automatic push_pulse(input int span);
    int low_run;
    low_run = $urandom_range(1, span - 1);
    push_level(1'b0, low_run);
    push_level(1'b1, span - low_run);
  endtask

  // Interval length aimed at one of the three classes or at a limit exactly.
  function automatic int pick_span();
    int zl;
    int ol;
    int span;
    zl = dec_zero_limit;
    ol = dec_one_limit;
    span = $urandom_range(2, ol + 3);
    case ($urandom_range(0, 5))
      0, 1: if (zl > 2) span = $urandom_range(2, zl - 1);
      2, 3: if (ol > zl && ol > 2) span = $urandom_range((zl > 2) ? zl : 2, ol - 1);
      4:    span = ((ol > 2) ? ol : 2) + $urandom_range(0, 3);
      default: begin
        span = $urandom_range(0, 1) ? zl : ol;
        if (span < 2) span = 2;
      end
    endcase
    return span;
  endfunction

  // Leader edge, the given number of intervals, a closing edge and a quiet tail.
  task automatic push_frame(input int intervals, input logic broken);
    int span;
    push_level(1'b1, $urandom_range(1, 3));
    for (int i = 0; i < intervals + 1; i++) begin
      span = broken ? $urandom_range(2, dec_timeout + 4) : pick_span();
      push_pulse(span);
    end
    if (broken) push_level(1'b1, $urandom_range(0, dec_timeout + 4));
    else push_level(1'b1, dec_timeout + $urandom_range(1, 4));
  endtask

  task automatic push_noise(input int count);
    for (int i = 0; i < count; i++) pending_samples.push_back(1'($urandom_range(0, 1)));
  endtask

  // One phase of random settings and a handful of frames, mostly well formed.
  task automatic random_phase();
    int zl;
    int ol;
    int tmo;
    int pick;
    zl  = $urandom_range(2, 8);
    ol  = zl + $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) zl = 0;
    if ($urandom_range(0, 9) == 0) ol = $urandom_range(0, zl);
    tmo = ol + $urandom_range(3, 10);
    apply_settings(($urandom_range(0, 11) != 0), tmo, zl, ol);
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      push_frame($urandom_range(MAX_INTERVALS, MAX_INTERVALS + 3), 1'b0);
      else if (pick < 7) push_frame($urandom_range(0, MAX_INTERVALS - 1), 1'b0);
      else if (pick < 9) push_frame($urandom_range(0, MAX_INTERVALS + 7), 1'b1);
      else               push_noise($urandom_range(5, 40));
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    int phase_count;
    phase_count    = 0;
    dec_enable     = 1'b0;
    dec_timeout    = irpd_pkg::TIMEOUT_RESET;
    dec_zero_limit = irpd_pkg::ZERO_LIMIT_RESET;
    dec_one_limit  = irpd_pkg::ONE_LIMIT_RESET;
    dec_last_level = 1'b1;
    dec_in_frame   = 1'b0;
    dec_index      = '0;
    dec_ticks      = '0;
    dec_bits       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the block is disabled, so these edges start nothing.
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    wait_idle();

    // Zero timeout acts as one tick: the frame ends on the sample after its edge.
    apply_settings(1'b1, 0, 0, 65535);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    wait_idle();

    // A one-interval frame that times out, then a frame left open.
    apply_settings(1'b1, 4, 2, 3);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 5);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    wait_idle();

    // Disabled with the frame open: edges are ignored but the timeout still runs.
    apply_settings(1'b0, 4, 2, 3);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    wait_idle();

    // Largest settings: the frame opened here is closed by the next phase.
    apply_settings(1'b1, 1048575, 65535, 65535);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    wait_idle();

    while (samples_accepted < TARGET_SAMPLES) begin
      phase_count++;
      if (phase_count == HOLD_OFF_PHASE) begin
        // Short frames against a stalled receiver, so the block backs up.
        apply_settings(1'b1, 6, 2, 4);
        hold_requests++;
        repeat (15) push_frame($urandom_range(0, 3), 1'b0);
      end else begin
        random_phase();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (result_errors == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/irpd_pkg.sv
rtl/irpd_cfg_regs.sv
rtl/irpd_frame_core.sv
rtl/ir_pulse_distance_command_decoder.sv
rtl/irpd_checker.sv
tb/testbench.sv
